// ===== hdl/slbs_pkg.sv =====
`timescale 1ns / 1ps

package slbs_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_PERCENT = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_ADD     = 3'd3,
        OP_REMOVE  = 3'd4
    } op_t;

    localparam logic [1:0] PH_NONE     = 2'd0;
    localparam logic [1:0] PH_CHECK    = 2'd1;
    localparam logic [1:0] PH_WARN     = 2'd2;
    localparam logic [1:0] PH_CRITICAL = 2'd3;

    localparam int NUM_SECT    = 3;
    localparam int MAX_RESULTS = 3;
    localparam int ADDR_W      = 5;

    localparam logic [2:0] REG_CHECK_RELOAD    = 3'd0;
    localparam logic [2:0] REG_WARN_RELOAD     = 3'd1;
    localparam logic [2:0] REG_CRITICAL_RELOAD = 3'd2;
    localparam logic [2:0] REG_DWELL_SECONDS   = 3'd3;
    localparam logic [2:0] REG_CRITICAL_THRESH = 3'd4;
    localparam logic [2:0] REG_CHECK_THRESH    = 3'd5;
    localparam logic [2:0] REG_WARN_THRESH     = 3'd6;

    localparam logic [7:0] MAX_PERCENT = 8'd100;

    typedef struct packed {
        logic [7:0] check_reload;
        logic [7:0] warn_reload;
        logic [7:0] critical_reload;
        logic [7:0] dwell_seconds;
        logic [6:0] critical_threshold;
        logic [6:0] check_threshold;
        logic [6:0] warn_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        check_reload:       8'd20,
        warn_reload:        8'd10,
        critical_reload:    8'd2,
        dwell_seconds:      8'd5,
        critical_threshold: 7'd10,
        check_threshold:    7'd20,
        warn_threshold:     7'd30
    };

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] signal_percent;
        logic [2:0] flag_mask;
        logic [31:0] now_seconds;
    } item_t;

    typedef struct packed {
        logic [2:0]             flags;
        logic [1:0]             phase;
        logic [7:0]             counter;
        logic                   level;
        logic                   off_written;
        logic [NUM_SECT-1:0][31:0] start;
        logic [NUM_SECT-1:0]    armed;
    } state_t;

    typedef struct packed {
        logic led_written;
        logic led_level;
        logic bad_percent;
    } res_t;

    typedef res_t [MAX_RESULTS-1:0] res_arr_t;

endpackage

// ===== hdl/slbs_in_if.sv =====
`timescale 1ns / 1ps

interface slbs_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  signal_percent;
    logic [2:0]  flag_mask;
    logic [31:0] now_seconds;

    modport source (
        output valid, operation, signal_percent, flag_mask, now_seconds,
        input  ready
    );
    modport sink (
        input  valid, operation, signal_percent, flag_mask, now_seconds,
        output ready
    );
endinterface

// ===== hdl/slbs_out_if.sv =====
`timescale 1ns / 1ps

interface slbs_out_if;
    logic valid;
    logic ready;
    logic led_written;
    logic led_level;
    logic bad_percent;
    logic last_result;

    modport source (
        output valid, led_written, led_level, bad_percent, last_result,
        input  ready
    );
    modport sink (
        input  valid, led_written, led_level, bad_percent, last_result,
        output ready
    );
endinterface

// ===== hdl/slbs_core.sv =====
`timescale 1ns / 1ps

module slbs_core
    import slbs_pkg::*;
(
    input  state_t     st,
    input  cfg_t       cfg,
    input  item_t      item,
    output state_t     st_next,
    output res_arr_t   res,
    output logic [1:0] res_cnt
);

    logic [NUM_SECT-1:0][7:0] reload;

    assign reload[0] = cfg.check_reload;
    assign reload[1] = cfg.warn_reload;
    assign reload[2] = cfg.critical_reload;

    always_comb
    begin
        state_t      s;
        logic [1:0]  n;
        logic        bad;
        logic [1:0]  me;
        logic [1:0]  nxt;
        logic [32:0] due;

        s   = st;
        n   = 2'd0;
        bad = 1'b0;
        res = '0;
        me  = PH_NONE;
        nxt = PH_NONE;
        due = '0;

        case (item.operation)
            OP_TICK:
            begin
                if (s.flags != 3'd0)
                begin
                    // sections run in order; each sees what the one before left
                    for (int i = 0; i < NUM_SECT; i++)
                    begin
                        me  = 2'(i + 1);
                        nxt = (i == NUM_SECT - 1) ? PH_CHECK : 2'(i + 2);
                        if (!s.flags[i])
                        begin
                            s.phase = nxt;
                        end
                        else if (s.phase == PH_NONE || s.phase == me)
                        begin
                            if (!s.armed[i])
                            begin
                                s.start[i] = item.now_seconds;
                                s.armed[i] = 1'b1;
                            end
                            if (s.counter == 8'd0)
                            begin
                                res[n]    = '{led_written: 1'b1, led_level: s.level,
                                              bad_percent: 1'b0};
                                n         = n + 2'd1;
                                s.level   = ~s.level;
                                s.counter = reload[i];
                            end
                            else
                            begin
                                s.counter = s.counter - 8'd1;
                            end
                            due = {1'b0, s.start[i]} + {25'd0, cfg.dwell_seconds};
                            if (due < {1'b0, item.now_seconds})
                            begin
                                s.phase    = nxt;
                                s.armed[i] = 1'b0;
                                s.start[i] = 32'd0;
                            end
                        end
                    end
                    s.off_written = 1'b0;
                end
                else if (!s.off_written)
                begin
                    res[0]        = '{led_written: 1'b1, led_level: 1'b0, bad_percent: 1'b0};
                    n             = 2'd1;
                    s.off_written = 1'b1;
                end
            end
            OP_PERCENT:
            begin
                if (item.signal_percent <= MAX_PERCENT)
                begin
                    if (item.signal_percent <= {1'b0, cfg.critical_threshold})
                        s.flags[2] = 1'b1;
                    else if (item.signal_percent <= {1'b0, cfg.check_threshold})
                        s.flags[0] = 1'b1;
                    else if (item.signal_percent <= {1'b0, cfg.warn_threshold})
                        s.flags[1] = 1'b1;
                    else
                        s.flags = 3'd0;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                s.flags = 3'd0;
            end
            OP_ADD:
            begin
                s.flags = s.flags | item.flag_mask;
            end
            OP_REMOVE:
            begin
                s.flags = s.flags & ~item.flag_mask;
            end
            default:
            begin
            end
        endcase

        if (n == 2'd0)
        begin
            res[0] = '{led_written: 1'b0, led_level: 1'b0, bad_percent: bad};
            n      = 2'd1;
        end

        st_next = s;
        res_cnt = n;
    end

endmodule

// ===== hdl/severity_led_blink_sequencer_unit.sv =====
`timescale 1ns / 1ps

// Severity LED blink sequencer. Each input beat is registered, then processed into a
// small result buffer. While the sink is ready, the buffer drains one beat per cycle,
// and an item that yields one result (every non-tick operation, and most ticks)
// sustains one item per cycle; a tick that writes the LED k times (k up to 3) holds the
// buffer, and so the next item, until its k results drain. Configuration registers sit
// on the APB port at byte address 4*i and must only be written while the block is idle.
module severity_led_blink_sequencer_unit
    import slbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    slbs_in_if.sink           in_ch,
    slbs_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t       cfg_reg;
    state_t     st_reg;
    state_t     st_next;
    item_t      item_reg;
    logic       item_valid_reg;
    res_arr_t   res_reg;
    res_arr_t   res_next;
    logic [1:0] res_cnt_reg;
    logic [1:0] res_cnt_next;
    logic [1:0] rd_ptr_reg;
    logic       res_valid_reg;
    logic       cur_last;
    logic       buf_free;
    logic       fire;
    logic       in_take;
    res_t       cur_res;

    // ---------------- APB ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[ADDR_W-1:2])
                REG_CHECK_RELOAD:    cfg_reg.check_reload       <= pwdata[7:0];
                REG_WARN_RELOAD:     cfg_reg.warn_reload        <= pwdata[7:0];
                REG_CRITICAL_RELOAD: cfg_reg.critical_reload    <= pwdata[7:0];
                REG_DWELL_SECONDS:   cfg_reg.dwell_seconds      <= pwdata[7:0];
                REG_CRITICAL_THRESH: cfg_reg.critical_threshold <= pwdata[6:0];
                REG_CHECK_THRESH:    cfg_reg.check_threshold    <= pwdata[6:0];
                REG_WARN_THRESH:     cfg_reg.warn_threshold     <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[ADDR_W-1:2])
            REG_CHECK_RELOAD:    prdata = {24'd0, cfg_reg.check_reload};
            REG_WARN_RELOAD:     prdata = {24'd0, cfg_reg.warn_reload};
            REG_CRITICAL_RELOAD: prdata = {24'd0, cfg_reg.critical_reload};
            REG_DWELL_SECONDS:   prdata = {24'd0, cfg_reg.dwell_seconds};
            REG_CRITICAL_THRESH: prdata = {25'd0, cfg_reg.critical_threshold};
            REG_CHECK_THRESH:    prdata = {25'd0, cfg_reg.check_threshold};
            REG_WARN_THRESH:     prdata = {25'd0, cfg_reg.warn_threshold};
            default:             prdata = 32'd0;
        endcase
    end

    // ---------------- datapath ----------------
    slbs_core u_core (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next),
        .res_cnt (res_cnt_next)
    );

    assign cur_last = (rd_ptr_reg == res_cnt_reg - 2'd1);
    assign buf_free = !res_valid_reg || (out_ch.ready && cur_last);
    assign fire     = item_valid_reg && buf_free;
    assign in_take  = in_ch.valid && in_ch.ready;

    assign in_ch.ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            st_reg         <= '0;
            res_valid_reg  <= 1'b0;
            res_cnt_reg    <= 2'd0;
            rd_ptr_reg     <= 2'd0;
        end
        else
        begin
            if (in_ch.ready)
                item_valid_reg <= in_ch.valid;

            if (fire)
            begin
                st_reg        <= st_next;
                res_valid_reg <= 1'b1;
                res_cnt_reg   <= res_cnt_next;
                rd_ptr_reg    <= 2'd0;
            end
            else if (res_valid_reg && out_ch.ready)
            begin
                if (cur_last)
                    res_valid_reg <= 1'b0;
                else
                    rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.operation      <= in_ch.operation;
            item_reg.signal_percent <= in_ch.signal_percent;
            item_reg.flag_mask      <= in_ch.flag_mask;
            item_reg.now_seconds    <= in_ch.now_seconds;
        end
        if (fire)
            res_reg <= res_next;
    end

    always_comb
    begin
        case (rd_ptr_reg)
            2'd0:    cur_res = res_reg[0];
            2'd1:    cur_res = res_reg[1];
            default: cur_res = res_reg[2];
        endcase
    end

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.led_written = cur_res.led_written;
    assign out_ch.led_level   = cur_res.led_level;
    assign out_ch.bad_percent = cur_res.bad_percent;
    assign out_ch.last_result = cur_last;

`ifndef SYNTH
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_cnt_reg != 2'd0) && (rd_ptr_reg < res_cnt_reg))
        else $error("result pointer beyond count");

    a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (!res_valid_reg || (out_ch.ready && cur_last)))
        else $error("item processed over pending results");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_ch.ready && cur_last && !fire) |=> !res_valid_reg)
        else $error("result buffer not emptied after last beat");

    a_off_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item_reg.operation == OP_TICK && st_reg.flags != 3'd0)
            |=> !st_reg.off_written)
        else $error("off latch kept across tick with flags");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import slbs_pkg::*;
;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [2:0] FLAG_CHECK     = 3'b001;
    localparam logic [2:0] FLAG_WARN      = 3'b010;
    localparam logic [2:0] FLAG_CRITICAL  = 3'b100;
    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic written;
        logic level;
        logic bad;
        logic last;
    } led_beat_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    slbs_in_if  in_if ();
    slbs_out_if out_if ();

    severity_led_blink_sequencer_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // sequencer state mirror
    cfg_t        cfg;
    logic [2:0]  sev_flags;
    logic [1:0]  cur_phase;
    logic [7:0]  blink_cnt;
    logic        led_level_next;
    logic        off_done;
    logic [31:0] phase_start [3];
    logic        start_armed [3];

    item_t       cmd_backlog [$];
    led_beat_t   led_beats_due [$];
    logic [31:0] wall_s;

    int   src_gap = 0;
    int   src_idle_pct = 0;
    logic src_valid_nxt;
    int   sink_hold = 0;
    int   sink_idle_pct = 0;
    int   hold_req = 0;
    int   hold_taken = 0;
    logic sink_ready_nxt;
    int   beat_errors = 0;
    int   idle_cycles = 0;
    led_beat_t seen_beat;
    led_beat_t want_beat;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic item_t make_item(input logic [2:0] op, input logic [7:0] pct,
                                        input logic [2:0] mask, input logic [31:0] now);
        item_t it;
        it.operation      = op;
        it.signal_percent = pct;
        it.flag_mask      = mask;
        it.now_seconds    = now;
        return it;
    endfunction

    function automatic void predict_led_beats(input item_t it);
        led_beat_t   made [$];
        led_beat_t   one;
        logic [1:0]  nxt;
        logic [7:0]  reload_v;
        logic [32:0] deadline;
        logic        bad;
        bad = 1'b0;
        case (it.operation)
            OP_TICK:
            begin
                if (sev_flags != 3'b000)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        nxt = (k == 0) ? PH_WARN : (k == 1) ? PH_CRITICAL : PH_CHECK;
                        reload_v = (k == 0) ? cfg.check_reload :
                                   (k == 1) ? cfg.warn_reload : cfg.critical_reload;
                        if (!sev_flags[k])
                        begin
                            cur_phase = nxt;
                            continue;
                        end
                        if (cur_phase != PH_NONE && cur_phase != 2'(k + 1))
                            continue;
                        if (!start_armed[k])
                        begin
                            phase_start[k] = it.now_seconds;
                            start_armed[k] = 1'b1;
                        end
                        if (blink_cnt == 8'd0)
                        begin
                            one = '{1'b1, led_level_next, 1'b0, 1'b0};
                            made.push_back(one);
                            led_level_next = ~led_level_next;
                            blink_cnt = reload_v;
                        end
                        else
                            blink_cnt = blink_cnt - 8'd1;
                        deadline = {1'b0, phase_start[k]} + 33'(cfg.dwell_seconds);
                        if (deadline < {1'b0, it.now_seconds})
                        begin
                            cur_phase = nxt;
                            start_armed[k] = 1'b0;
                            phase_start[k] = 32'd0;
                        end
                    end
                    off_done = 1'b0;
                end
                else if (!off_done)
                begin
                    one = '{1'b1, 1'b0, 1'b0, 1'b0};
                    made.push_back(one);
                    off_done = 1'b1;
                end
            end
            OP_PERCENT:
            begin
                if (it.signal_percent <= MAX_PERCENT)
                begin
                    if (it.signal_percent <= 8'(cfg.critical_threshold))
                        sev_flags = sev_flags | FLAG_CRITICAL;
                    else if (it.signal_percent <= 8'(cfg.check_threshold))
                        sev_flags = sev_flags | FLAG_CHECK;
                    else if (it.signal_percent <= 8'(cfg.warn_threshold))
                        sev_flags = sev_flags | FLAG_WARN;
                    else
                        sev_flags = 3'b000;
                end
                else
                    bad = 1'b1;
            end
            OP_CLEAR:
                sev_flags = 3'b000;
            OP_ADD:
                sev_flags = sev_flags | it.flag_mask;
            OP_REMOVE:
                sev_flags = sev_flags & ~it.flag_mask;
            default:
                ;
        endcase
        if (made.size() == 0)
        begin
            one = '{1'b0, 1'b0, bad, 1'b0};
            made.push_back(one);
        end
        made[made.size() - 1].last = 1'b1;
        foreach (made[i])
            led_beats_due.push_back(made[i]);
    endfunction

    function automatic void report_beat(input string what, input led_beat_t want,
                                        input led_beat_t got);
        beat_errors++;
        if (beat_errors <= 10)
            $display("%0t %0s: expected wr=%0b lvl=%0b bad=%0b last=%0b,",
                     $realtime, what, want.written, want.level, want.bad, want.last,
                     " got wr=%0b lvl=%0b bad=%0b last=%0b",
                     got.written, got.level, got.bad, got.last);
    endfunction

    // command driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            src_valid_nxt = in_if.valid;
            if (in_if.valid && in_if.ready)
            begin
                predict_led_beats(cmd_backlog.pop_front());
                src_valid_nxt = 1'b0;
                if ($urandom_range(0, 99) < src_idle_pct)
                    src_gap = pick_gap();
            end
            if (!src_valid_nxt)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (cmd_backlog.size() != 0)
                begin
                    src_valid_nxt = 1'b1;
                    in_if.operation      <= cmd_backlog[0].operation;
                    in_if.signal_percent <= cmd_backlog[0].signal_percent;
                    in_if.flag_mask      <= cmd_backlog[0].flag_mask;
                    in_if.now_seconds    <= cmd_backlog[0].now_seconds;
                end
            end
            in_if.valid <= src_valid_nxt;
        end
    end

    // LED beat monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
            begin
                seen_beat = '{out_if.led_written, out_if.led_level, out_if.bad_percent,
                              out_if.last_result};
                if (led_beats_due.size() == 0)
                    report_beat("unexpected beat", '0, seen_beat);
                else
                begin
                    want_beat = led_beats_due.pop_front();
                    if (seen_beat.written !== want_beat.written ||
                        seen_beat.level !== want_beat.level ||
                        seen_beat.bad !== want_beat.bad ||
                        seen_beat.last !== want_beat.last)
                        report_beat("beat mismatch", want_beat, seen_beat);
                end
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                sink_ready_nxt = 1'b0;
            end
            else if (hold_req != hold_taken)
            begin
                hold_taken = hold_req;
                sink_hold = LONG_HOLD;
                sink_ready_nxt = 1'b0;
            end
            else if ($urandom_range(0, 99) < sink_idle_pct)
            begin
                sink_hold = pick_gap() - 1;
                sink_ready_nxt = 1'b0;
            end
            else
                sink_ready_nxt = 1'b1;
            out_if.ready <= sink_ready_nxt;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHECK_RELOAD:    cfg.check_reload       = val[7:0];
            REG_WARN_RELOAD:     cfg.warn_reload        = val[7:0];
            REG_CRITICAL_RELOAD: cfg.critical_reload    = val[7:0];
            REG_DWELL_SECONDS:   cfg.dwell_seconds      = val[7:0];
            REG_CRITICAL_THRESH: cfg.critical_threshold = val[6:0];
            REG_CHECK_THRESH:    cfg.check_threshold    = val[6:0];
            REG_WARN_THRESH:     cfg.warn_threshold     = val[6:0];
            default:             ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] chk_rl, input logic [7:0] wrn_rl,
                                input logic [7:0] crt_rl, input logic [7:0] dwell,
                                input logic [6:0] crt_th, input logic [6:0] chk_th,
                                input logic [6:0] wrn_th);
        reg_write(REG_CHECK_RELOAD, 32'(chk_rl));
        reg_write(REG_WARN_RELOAD, 32'(wrn_rl));
        reg_write(REG_CRITICAL_RELOAD, 32'(crt_rl));
        reg_write(REG_DWELL_SECONDS, 32'(dwell));
        reg_write(REG_CRITICAL_THRESH, 32'(crt_th));
        reg_write(REG_CHECK_THRESH, 32'(chk_th));
        reg_write(REG_WARN_THRESH, 32'(wrn_th));
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0 || in_if.valid)
            @(posedge clk);
        while (led_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic queue_directed();
        logic [7:0] p;
        logic [2:0] m;
        p = 8'($urandom());
        m = 3'($urandom());
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'd0));
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'd1));
        cmd_backlog.push_back(make_item(OP_PERCENT, 8'd101, m, 32'($urandom())));
        cmd_backlog.push_back(make_item(OP_PERCENT, 8'd255, m, 32'($urandom())));
        // exact threshold hits
        cmd_backlog.push_back(make_item(OP_PERCENT, 8'd10, m, 32'd0));
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'd2));
        cmd_backlog.push_back(make_item(OP_PERCENT, 8'd20, m, 32'd0));
        cmd_backlog.push_back(make_item(OP_PERCENT, 8'd30, m, 32'd0));
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'd3));
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'd9));
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'd12));
        cmd_backlog.push_back(make_item(OP_PERCENT, 8'd31, m, 32'd0));
        cmd_backlog.push_back(make_item(OP_ADD, p, 3'b111, 32'd0));
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'hFFFF_FFFF));
        // clock going backwards
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'hFFFF_FFF0));
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'd5));
        cmd_backlog.push_back(make_item(OP_REMOVE, p, 3'b101, 32'd0));
        cmd_backlog.push_back(make_item(OP_ADD, p, 3'b000, 32'd0));
        cmd_backlog.push_back(make_item(OP_REMOVE, p, 3'b010, 32'd0));
        cmd_backlog.push_back(make_item(OP_SPARE_FIRST, 8'd0, 3'b111, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_item(OP_SPARE_FIRST + 3'd1, 8'd255, 3'b000, 32'd0));
        cmd_backlog.push_back(make_item(OP_SPARE_LAST, p, m, 32'($urandom())));
        cmd_backlog.push_back(make_item(OP_PERCENT, 8'd100, m, 32'd0));
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'd40));
        cmd_backlog.push_back(make_item(OP_TICK, p, m, 32'd41));
    endtask

    task automatic queue_random(input int count);
        int         r;
        int         t;
        logic [2:0] op;
        logic [7:0] pct;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            t = $urandom_range(0, 99);
            if (r < 50)
                op = OP_TICK;
            else if (r < 70)
                op = OP_PERCENT;
            else if (r < 81)
                op = OP_ADD;
            else if (r < 90)
                op = OP_REMOVE;
            else if (r < 96)
                op = OP_CLEAR;
            else
                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            if ($urandom_range(0, 99) < 85)
                pct = 8'($urandom_range(0, MAX_PERCENT));
            else
                pct = 8'($urandom_range(MAX_PERCENT + 1, 255));
            if (t < 4)
                wall_s = $urandom();
            else if (t < 7)
                wall_s = wall_s - 32'($urandom_range(1, 8));
            else
                wall_s = wall_s + 32'($urandom_range(0, 3));
            cmd_backlog.push_back(make_item(op, pct, 3'($urandom()), wall_s));
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        in_if.valid          = 1'b0;
        in_if.operation      = '0;
        in_if.signal_percent = '0;
        in_if.flag_mask      = '0;
        in_if.now_seconds    = '0;
        out_if.ready         = 1'b0;

        cfg.check_reload       = 8'd20;
        cfg.warn_reload        = 8'd10;
        cfg.critical_reload    = 8'd2;
        cfg.dwell_seconds      = 8'd5;
        cfg.critical_threshold = 7'd10;
        cfg.check_threshold    = 7'd20;
        cfg.warn_threshold     = 7'd30;
        sev_flags      = 3'b000;
        cur_phase      = PH_NONE;
        blink_cnt      = 8'd0;
        led_level_next = 1'b0;
        off_done       = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            phase_start[k] = 32'd0;
            start_armed[k] = 1'b0;
        end
        wall_s = 32'd50;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct  = 30;
        sink_idle_pct = 30;
        queue_directed();
        queue_random(55);
        drain();

        // fastest blink, zero dwell, no idling
        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 7'd0, 7'd0, 7'd0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        queue_random(60);
        drain();

        program_regs(8'd255, 8'd255, 8'd255, 8'd255, 7'd100, 7'd100, 7'd100);
        src_idle_pct  = 40;
        sink_idle_pct = 20;
        queue_random(60);
        drain();

        // thresholds out of order, up to 127
        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 30)),
                     8'($urandom_range(0, 30)), 8'($urandom_range(0, 10)),
                     7'($urandom()), 7'($urandom()), 7'($urandom()));
        src_idle_pct  = 20;
        sink_idle_pct = 40;
        queue_random(60);
        drain();

        program_regs(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 3)), 8'($urandom_range(0, 2)),
                     7'd15, 7'd40, 7'd70);
        src_idle_pct  = 10;
        sink_idle_pct = 10;
        queue_random(60);
        hold_req++;
        drain();

        if (beat_errors == 0 && led_beats_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/slbs_pkg.sv
hdl/slbs_in_if.sv
hdl/slbs_out_if.sv
hdl/slbs_core.sv
hdl/severity_led_blink_sequencer_unit.sv
sim/testbench.sv
